// ----- rtl/jps_pkg.sv -----
// shared types and constants of the jacobi stencil sweep
package jps_pkg;

	localparam int MAX_PADDED_WIDTH = 1024;
	localparam int LINE_AW = $clog2(MAX_PADDED_WIDTH);
	localparam int COL_W = 10;
	localparam int ROW_W = 16;
	localparam int VALUE_W = 32;
	localparam int RESID_W = 63;
	localparam int CFG_DATA_W = 32;
	localparam int REG_IDX_W = 2;
	localparam int MAX_COLS = MAX_PADDED_WIDTH - 2;
	localparam int MAX_ROWS = 65533;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// configuration register indexes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_INTERIOR_COLUMNS = 2'd0,
		REG_INTERIOR_ROWS = 2'd1,
		REG_SPACING_SQUARED = 2'd2,
		REG_INVERSE_SPACING_SQUARED = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [COL_W-1:0] interior_columns;
		logic [ROW_W-1:0] interior_rows;
		logic [31:0] spacing_squared;
		logic [31:0] inverse_spacing_squared;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		interior_columns: COL_W'(1022),
		interior_rows: ROW_W'(1022),
		spacing_squared: 32'd4096,
		inverse_spacing_squared: 32'd268435456
	};

	// one column of the line store: value two rows up, value one row up, source one row up
	typedef struct packed {
		logic [VALUE_W-1:0] upper;
		logic [VALUE_W-1:0] middle;
		logic [VALUE_W-1:0] source;
	} line_entry_t;

	// neighborhood of one interior cell, handed from front to back
	typedef struct packed {
		logic [VALUE_W-1:0] north;
		logic [VALUE_W-1:0] west;
		logic [VALUE_W-1:0] ctr;
		logic [VALUE_W-1:0] east;
		logic [VALUE_W-1:0] south;
		logic [VALUE_W-1:0] src;
		logic last;
	} stencil_t;

endpackage

// ----- rtl/jps_cell_if.sv -----
// input channel: one padded-grid cell per beat
interface jps_cell_if import jps_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [VALUE_W-1:0] cell_value;
	logic signed [VALUE_W-1:0] source_value;

	modport source (output valid, cell_value, source_value, input ready);
	modport sink (input valid, cell_value, source_value, output ready);
endinterface

// ----- rtl/jps_result_if.sv -----
// output channel: one jacobi update per beat, residual sum on the last one
interface jps_result_if import jps_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [VALUE_W-1:0] updated_value;
	logic [RESID_W-1:0] residual_sum;
	logic last;

	modport source (output valid, updated_value, residual_sum, last, input ready);
	modport sink (input valid, updated_value, residual_sum, last, output ready);
endinterface

// ----- rtl/jacobi_poisson_stencil_sweep_top.sv -----
// Jacobi 5-point stencil sweep: takes one padded-grid cell per cycle while the queue has room.
// A result follows the cell below its center through queue, stages and output register.
// Sustained rate is one cell per cycle, set by the single line-store write per accepted cell.
// A 4-entry queue lets the input keep flowing while the result side stalls.
// arst_n clears positions, line-store fill count, accumulator and all valids at once,
// and loads the default geometry; no clearing pass is run.
module jacobi_poisson_stencil_sweep_top import jps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic write_enable,
	input logic [REG_IDX_W-1:0] register_index,
	input logic [CFG_DATA_W-1:0] write_data,
	jps_cell_if.sink cell_in,
	jps_result_if.source result_out
);

	cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	stencil_t push_data;
	logic head_valid;
	stencil_t head;
	logic take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (write_enable) begin
			case (reg_index_t'(register_index))
				REG_INTERIOR_COLUMNS: cfg_q.interior_columns <= write_data[COL_W-1:0];
				REG_INTERIOR_ROWS: cfg_q.interior_rows <= write_data[ROW_W-1:0];
				REG_SPACING_SQUARED: cfg_q.spacing_squared <= write_data;
				REG_INVERSE_SPACING_SQUARED: cfg_q.inverse_spacing_squared <= write_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	jps_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cell_in(cell_in),
		.push_ready(push_ready),
		.push_valid(push_valid),
		.push_data(push_data)
	);

	jps_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_data(push_data),
		.push_ready(push_ready),
		.head_valid(head_valid),
		.head(head),
		.take(take)
	);

	jps_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head_valid(head_valid),
		.head(head),
		.take(take),
		.result_out(result_out)
	);

	// residual sum only rides on the last beat of a grid
	a_resid_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && !result_out.last |-> result_out.residual_sum == '0)
		else $error("residual sum on a beat that is not last");

	// back end never pulls from an empty queue
	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> head_valid)
		else $error("queue popped while empty");

	// input backpressure only comes from a full queue
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cell_in.ready |-> head_valid)
		else $error("input stalled with empty queue");

endmodule

// ----- rtl/jps_front.sv -----
// front end: raster position tracking, line store and stencil gathering
module jps_front import jps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	jps_cell_if.sink cell_in,
	input logic push_ready,
	output logic push_valid,
	output stencil_t push_data
);

	line_entry_t line_mem [MAX_PADDED_WIDTH];

	logic [LINE_AW-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [LINE_AW:0] fill_q;
	line_entry_t cur_q;
	logic [VALUE_W-1:0] east_q;
	logic [VALUE_W-1:0] west_q;
	logic cur_ok_q;
	logic east_ok_q;

	logic [COL_W-1:0] cols_c;
	logic [ROW_W-1:0] rows_c;
	logic [COL_W-1:0] last_col_c;
	logic [ROW_W-1:0] last_row_c;
	logic accept;
	logic emit_c;
	logic is_last_c;
	logic row_end_c;
	logic [LINE_AW-1:0] next_col_c;
	logic [ROW_W-1:0] next_row_c;
	logic [LINE_AW-1:0] east_addr_c;
	logic [LINE_AW:0] next_col_ext_c;
	logic next_ok_c;
	logic east_next_ok_c;
	logic [VALUE_W-1:0] cur_upper_c;
	logic [VALUE_W-1:0] cur_middle_c;
	logic [VALUE_W-1:0] east_c;

	// geometry clamped to the supported range
	always_comb begin
		if (cfg.interior_columns == '0) begin
			cols_c = COL_W'(1);
		end else if (cfg.interior_columns > COL_W'(MAX_COLS)) begin
			cols_c = COL_W'(MAX_COLS);
		end else begin
			cols_c = cfg.interior_columns;
		end
		if (cfg.interior_rows == '0) begin
			rows_c = ROW_W'(1);
		end else if (cfg.interior_rows > ROW_W'(MAX_ROWS)) begin
			rows_c = ROW_W'(MAX_ROWS);
		end else begin
			rows_c = cfg.interior_rows;
		end
		last_col_c = cols_c + COL_W'(1);
		last_row_c = rows_c + ROW_W'(1);
	end

	assign accept = cell_in.valid && cell_in.ready;
	assign cell_in.ready = push_ready;

	// classify the cell: the center sits one row above it
	always_comb begin
		emit_c = (row_q >= ROW_W'(2)) && (row_q <= last_row_c)
			&& (col_q != '0) && (col_q <= LINE_AW'(cols_c));
		is_last_c = (row_q == last_row_c) && (col_q == LINE_AW'(cols_c));
		row_end_c = col_q >= LINE_AW'(last_col_c);
		if (row_end_c) begin
			next_col_c = '0;
			next_row_c = (row_q >= last_row_c) ? '0 : row_q + ROW_W'(1);
		end else begin
			next_col_c = col_q + LINE_AW'(1);
			next_row_c = row_q;
		end
		east_addr_c = next_col_c + LINE_AW'(1);
		next_col_ext_c = {1'b0, next_col_c};
		next_ok_c = next_col_ext_c < fill_q;
		east_next_ok_c = (next_col_ext_c + (LINE_AW+1)'(1)) < fill_q;
	end

	// entries past the fill count were never written and read as zero
	assign cur_upper_c = cur_ok_q ? cur_q.upper : '0;
	assign cur_middle_c = cur_ok_q ? cur_q.middle : '0;
	assign east_c = east_ok_q ? east_q : '0;

	// gathered neighborhood into the queue
	assign push_valid = accept && emit_c;
	always_comb begin
		push_data.north = cur_upper_c;
		push_data.west = west_q;
		push_data.ctr = cur_middle_c;
		push_data.east = east_c;
		push_data.south = cell_in.cell_value;
		push_data.src = cur_q.source;
		push_data.last = is_last_c;
	end

	// line store: shift this column down a row, prefetch the next two columns
	always_ff @(posedge clk) begin
		if (accept) begin
			line_mem[col_q] <= '{upper: cur_middle_c, middle: cell_in.cell_value,
				source: cell_in.source_value};
			cur_q <= line_mem[next_col_c];
			east_q <= line_mem[east_addr_c].middle;
			west_q <= cur_middle_c;
		end
	end

	// position and fill tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			fill_q <= '0;
			cur_ok_q <= 1'b0;
			east_ok_q <= 1'b0;
		end else if (accept) begin
			col_q <= next_col_c;
			row_q <= next_row_c;
			cur_ok_q <= next_ok_c;
			east_ok_q <= east_next_ok_c;
			if ({1'b0, col_q} >= fill_q) begin
				fill_q <= {1'b0, col_q} + (LINE_AW+1)'(1);
			end
		end
	end

endmodule

// ----- rtl/jps_queue.sv -----
// short queue of gathered stencils between front and back
module jps_queue import jps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	input stencil_t push_data,
	output logic push_ready,
	output logic head_valid,
	output stencil_t head,
	input logic take
);

	stencil_t slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;
	logic push;

	assign push_ready = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head = slot_q[rd_ptr_q];
	assign push = push_valid && push_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, take})
				2'b10: count_q <= count_q + (QPTR_W+1)'(1);
				2'b01: count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/jps_back.sv -----
// back end: update and residual arithmetic pipeline with residual accumulator
module jps_back import jps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic head_valid,
	input stencil_t head,
	output logic take,
	jps_result_if.source result_out
);

	logic adv;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7, last_s8;

	logic signed [33:0] sum_c;
	logic signed [32:0] h2_c;
	logic signed [64:0] prod_c;
	logic signed [33:0] sum_s1;
	logic [VALUE_W-1:0] ctr_s1;
	logic [VALUE_W-1:0] src_s1;
	logic signed [63:0] prod_s1;

	logic signed [34:0] num_c;
	logic signed [63:0] round_c;
	logic signed [34:0] num_s2;
	logic signed [31:0] p_s2;
	logic signed [33:0] sum_s2;
	logic [VALUE_W-1:0] src_s2;

	logic [34:0] mag_c;
	logic signed [34:0] d_c;
	logic [34:0] mag_s3;
	logic neg_s3;
	logic signed [34:0] d_s3;
	logic [VALUE_W-1:0] src_s3;

	logic [50:0] hi_c;
	logic [50:0] lo_c;
	logic signed [35:0] rnd_c;
	logic signed [35:0] sh_c;
	logic [VALUE_W-1:0] upd_c;
	logic [50:0] hi_s4;
	logic [50:0] lo_s4;
	logic neg_s4;
	logic [VALUE_W-1:0] upd_s4;
	logic [VALUE_W-1:0] src_s4;

	logic [67:0] full_c;
	logic big_s5;
	logic [30:0] q_s5;
	logic neg_s5;
	logic [VALUE_W-1:0] upd_s5;
	logic [VALUE_W-1:0] src_s5;

	logic [VALUE_W-1:0] lap_c;
	logic [VALUE_W-1:0] lap_s6;
	logic [VALUE_W-1:0] upd_s6;
	logic [VALUE_W-1:0] src_s6;

	logic signed [32:0] diff_c;
	logic [32:0] dmag_c;
	logic [31:0] rmag_c;
	logic [31:0] rmag_s7;
	logic [VALUE_W-1:0] upd_s7;

	logic [63:0] sq_c;
	logic [RESID_W-1:0] sq_s8;
	logic [VALUE_W-1:0] upd_s8;

	logic [RESID_W:0] acc_sum_c;
	logic [RESID_W-1:0] acc_next_c;
	logic [RESID_W-1:0] acc_q;
	logic out_valid_q;
	logic [VALUE_W-1:0] updated_value_q;
	logic [RESID_W-1:0] residual_sum_q;
	logic last_q;

	// whole pipeline moves together when the output register can take a beat
	assign adv = !out_valid_q || result_out.ready;
	assign take = adv && head_valid;

	// stage 1: neighbor sum and h^2 * f product
	always_comb begin
		sum_c = $signed({{2{head.north[31]}}, head.north})
			+ $signed({{2{head.west[31]}}, head.west})
			+ $signed({{2{head.east[31]}}, head.east})
			+ $signed({{2{head.south[31]}}, head.south});
		h2_c = $signed({1'b0, cfg.spacing_squared});
		prod_c = h2_c * $signed(head.src);
	end

	// stage 2: laplacian numerator and rounded source term
	always_comb begin
		num_c = $signed({sum_s1[33], sum_s1}) - $signed({ctr_s1[31], ctr_s1, 2'b00});
		round_c = prod_s1 + 64'sd2147483648;
	end

	// stage 3: magnitude of the numerator, difference for the update
	always_comb begin
		mag_c = num_s2[34] ? 35'(-num_s2) : 35'(num_s2);
		d_c = $signed({sum_s2[33], sum_s2}) - $signed({{3{p_s2[31]}}, p_s2});
	end

	// stage 4: partial products of the scaled laplacian, rounded quarter
	always_comb begin
		hi_c = {16'b0, mag_s3} * {35'b0, cfg.inverse_spacing_squared[31:16]};
		lo_c = {16'b0, mag_s3} * {35'b0, cfg.inverse_spacing_squared[15:0]};
		rnd_c = $signed({d_s3[34], d_s3}) + 36'sd2;
		sh_c = rnd_c >>> 2;
		if (sh_c > 36'sd2147483647) begin
			upd_c = 32'h7FFF_FFFF;
		end else if (sh_c < -36'sd2147483648) begin
			upd_c = 32'h8000_0000;
		end else begin
			upd_c = sh_c[31:0];
		end
	end

	// stage 5: combine partial products and round Q.32 to Q.24
	assign full_c = {1'b0, hi_s4, 16'b0} + {17'b0, lo_s4} + 68'd128;

	// stage 6: signed and saturated laplacian
	always_comb begin
		if (big_s5) begin
			lap_c = neg_s5 ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else if (neg_s5) begin
			lap_c = -{1'b0, q_s5};
		end else begin
			lap_c = {1'b0, q_s5};
		end
	end

	// stage 7: saturated residual, kept as magnitude for squaring
	always_comb begin
		diff_c = $signed({lap_s6[31], lap_s6}) - $signed({src_s6[31], src_s6});
		dmag_c = diff_c[32] ? 33'(-diff_c) : 33'(diff_c);
		if (diff_c[32]) begin
			rmag_c = (dmag_c > 33'h0_8000_0000) ? 32'h8000_0000 : dmag_c[31:0];
		end else begin
			rmag_c = (dmag_c > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : dmag_c[31:0];
		end
	end

	// stage 8: square of the residual
	assign sq_c = rmag_s7 * rmag_s7;

	// saturating accumulation
	always_comb begin
		acc_sum_c = {1'b0, acc_q} + {1'b0, sq_s8};
		acc_next_c = acc_sum_c[RESID_W] ? '1 : acc_sum_c[RESID_W-1:0];
	end

	// stage valids, output valid and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q <= '0;
		end else if (adv) begin
			valid_s1 <= head_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			out_valid_q <= valid_s8;
			if (valid_s8) begin
				acc_q <= last_s8 ? '0 : acc_next_c;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1 <= sum_c;
			ctr_s1 <= head.ctr;
			src_s1 <= head.src;
			prod_s1 <= prod_c[63:0];
			last_s1 <= head.last;

			num_s2 <= num_c;
			p_s2 <= round_c[63:32];
			sum_s2 <= sum_s1;
			src_s2 <= src_s1;
			last_s2 <= last_s1;

			mag_s3 <= mag_c;
			neg_s3 <= num_s2[34];
			d_s3 <= d_c;
			src_s3 <= src_s2;
			last_s3 <= last_s2;

			hi_s4 <= hi_c;
			lo_s4 <= lo_c;
			neg_s4 <= neg_s3;
			upd_s4 <= upd_c;
			src_s4 <= src_s3;
			last_s4 <= last_s3;

			big_s5 <= |full_c[67:39];
			q_s5 <= full_c[38:8];
			neg_s5 <= neg_s4;
			upd_s5 <= upd_s4;
			src_s5 <= src_s4;
			last_s5 <= last_s4;

			lap_s6 <= lap_c;
			upd_s6 <= upd_s5;
			src_s6 <= src_s5;
			last_s6 <= last_s5;

			rmag_s7 <= rmag_c;
			upd_s7 <= upd_s6;
			last_s7 <= last_s6;

			sq_s8 <= sq_c[RESID_W-1:0];
			upd_s8 <= upd_s7;
			last_s8 <= last_s7;

			updated_value_q <= upd_s8;
			residual_sum_q <= last_s8 ? acc_next_c : '0;
			last_q <= last_s8;
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.updated_value = updated_value_q;
	assign result_out.residual_sum = residual_sum_q;
	assign result_out.last = last_q;

endmodule

// ----- tb/jps_sweep_check_pkg.sv -----
// scoreboard of the stencil sweep: mirrored line stores, jacobi update prediction, beat check
package jps_sweep_check_pkg;
	import jps_pkg::*;

	localparam longint unsigned RESID_CAP = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [VALUE_W-1:0] updated_value;
		logic [RESID_W-1:0] residual_sum;
		logic last;
	} stencil_update_t;

	class sweep_scoreboard;
		// mirrored registers
		logic [COL_W-1:0] interior_columns;
		logic [ROW_W-1:0] interior_rows;
		logic [31:0] spacing_squared;
		logic [31:0] inverse_spacing_squared;

		// mirrored line stores, raster position and residual sum
		logic [VALUE_W-1:0] upper_line [MAX_PADDED_WIDTH];
		logic [VALUE_W-1:0] middle_line [MAX_PADDED_WIDTH];
		logic [VALUE_W-1:0] source_line [MAX_PADDED_WIDTH];
		int unsigned col_pos;
		int unsigned row_pos;
		longint unsigned residual_acc;

		stencil_update_t pending_updates[$];
		int unsigned cells_noted;
		int unsigned updates_checked;
		int unsigned grids_closed;
		int unsigned mismatches;

		function new();
			interior_columns = CFG_RESET.interior_columns;
			interior_rows = CFG_RESET.interior_rows;
			spacing_squared = CFG_RESET.spacing_squared;
			inverse_spacing_squared = CFG_RESET.inverse_spacing_squared;
			foreach (upper_line[i]) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
				source_line[i] = '0;
			end
			col_pos = 0;
			row_pos = 0;
			residual_acc = 0;
			cells_noted = 0;
			updates_checked = 0;
			grids_closed = 0;
			mismatches = 0;
		endfunction

		function longint clamp_q824(longint x);
			if (x > 64'sd2147483647) return 64'sd2147483647;
			if (x < -64'sd2147483648) return -64'sd2147483648;
			return x;
		endfunction

		function void write_register(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_INTERIOR_COLUMNS: interior_columns = data[COL_W-1:0];
				REG_INTERIOR_ROWS: interior_rows = data[ROW_W-1:0];
				REG_SPACING_SQUARED: spacing_squared = data;
				REG_INVERSE_SPACING_SQUARED: inverse_spacing_squared = data;
				default: ;
			endcase
		endfunction

		// one accepted cell: predict the update centered above it, then shift the line stores
		function void note_cell(logic [VALUE_W-1:0] cell_val, logic [VALUE_W-1:0] source);
			int unsigned ncols, nrows, pw, ph, c, r;
			longint south, north, west, ctr, east, src, nbr_sum, hf, num, lap, resid;
			longint unsigned mag, hi, lo, q, sq;
			stencil_update_t upd;

			ncols = interior_columns;
			if (ncols < 1) ncols = 1;
			if (ncols > MAX_COLS) ncols = MAX_COLS;
			nrows = interior_rows;
			if (nrows < 1) nrows = 1;
			if (nrows > MAX_ROWS) nrows = MAX_ROWS;
			pw = ncols + 2;
			ph = nrows + 2;
			c = col_pos;
			r = row_pos;
			cells_noted++;

			if (r >= 2 && r <= ph - 1 && c >= 1 && c <= pw - 2) begin
				south = longint'($signed(cell_val));
				north = longint'($signed(upper_line[c]));
				west = longint'($signed(upper_line[c - 1]));
				ctr = longint'($signed(middle_line[c]));
				east = longint'($signed(middle_line[c + 1]));
				src = longint'($signed(source_line[c]));
				nbr_sum = north + west + east + south;

				// h^2 * f, exact Q.56 product rounded to Q.24
				hf = (longint'(spacing_squared) * src + 64'sd2147483648) >>> 32;
				upd.updated_value = 32'(clamp_q824((nbr_sum - hf + 2) >>> 2));

				// laplacian magnitude times 1/h^2, split multiply, half away from zero
				num = nbr_sum - 4 * ctr;
				if (num < 0) mag = -num;
				else mag = num;
				hi = mag * inverse_spacing_squared[31:16];
				lo = mag * inverse_spacing_squared[15:0];
				if (hi >= (64'd1 << 23)) begin
					q = 64'd1 << 32;
				end else begin
					q = ((hi << 16) + lo + 64'd128) >> 8;
					if (q > (64'd1 << 32)) q = 64'd1 << 32;
				end
				lap = clamp_q824((num < 0) ? -longint'(q) : longint'(q));
				resid = clamp_q824(lap - src);
				sq = resid * resid;

				// saturating residual sum, reported and cleared on the last interior cell
				residual_acc = (residual_acc > RESID_CAP - sq) ? RESID_CAP : residual_acc + sq;
				upd.last = (r == ph - 1) && (c == pw - 2);
				upd.residual_sum = upd.last ? residual_acc[RESID_W-1:0] : '0;
				if (upd.last) residual_acc = 0;
				pending_updates.push_back(upd);
			end

			upper_line[c] = middle_line[c];
			middle_line[c] = cell_val;
			source_line[c] = source;

			if (c >= pw - 1) begin
				col_pos = 0;
				row_pos = (r >= ph - 1) ? 0 : r + 1;
			end else begin
				col_pos = c + 1;
			end
		endfunction

		// one result beat against the oldest pending update
		function void check_result(logic [VALUE_W-1:0] updated_value,
				logic [RESID_W-1:0] residual_sum, logic last);
			stencil_update_t want;
			if (pending_updates.size() == 0) begin
				$error("result beat with no update pending: updated_value %0d",
					$signed(updated_value));
				mismatches++;
				return;
			end
			want = pending_updates.pop_front();
			updates_checked++;
			if (want.last) grids_closed++;
			if (updated_value !== want.updated_value) begin
				$error("updated_value: expected %0d, actual %0d",
					$signed(want.updated_value), $signed(updated_value));
				mismatches++;
			end
			if (residual_sum !== want.residual_sum) begin
				$error("residual_sum: expected %0d, actual %0d", want.residual_sum, residual_sum);
				mismatches++;
			end
			if (last !== want.last) begin
				$error("last: expected %0b, actual %0b", want.last, last);
				mismatches++;
			end
		endfunction
	endclass

endpackage

// ----- tb/jacobi_poisson_stencil_sweep_top_tb.sv -----
// testbench top: streams padded grids through the stencil sweep and checks every jacobi update
module jacobi_poisson_stencil_sweep_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import jps_pkg::*;
	import jps_sweep_check_pkg::*;

	localparam int unsigned DRAIN_CYCLES = 24;
	localparam int unsigned LONG_HOLD_CYCLES = 200;
	localparam int unsigned CELLS_PER_PHASE = 75;
	localparam int unsigned TIMEOUT_NS = 4_000_000;
	localparam logic [VALUE_W-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0] Q_MIN = 32'h8000_0000;

	logic clk = 1'b0;
	logic arst_n;
	logic write_enable;
	logic [REG_IDX_W-1:0] register_index;
	logic [CFG_DATA_W-1:0] write_data;

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit long_hold_req;

	jps_cell_if cell_ch();
	jps_result_if result_ch();

	sweep_scoreboard sb = new();

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	jacobi_poisson_stencil_sweep_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.write_enable(write_enable),
		.register_index(register_index),
		.write_data(write_data),
		.cell_in(cell_ch),
		.result_out(result_ch)
	);

	// result side: check each beat, then choose the next ready
	initial begin : result_sink
		int unsigned hold_left;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				sb.check_result(result_ch.updated_value, result_ch.residual_sum, result_ch.last);
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// register write: strobe write_enable, then drop it and mirror the write in the scoreboard
	task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		write_enable <= 1'b1;
		register_index <= idx;
		write_data <= data;
		@(posedge clk);
		sb.write_register(idx, data);
		write_enable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int unsigned cols, input int unsigned rows,
			input logic [31:0] hsq, input logic [31:0] inv);
		write_reg(REG_INTERIOR_COLUMNS, cols);
		write_reg(REG_INTERIOR_ROWS, rows);
		write_reg(REG_SPACING_SQUARED, hsq);
		write_reg(REG_INVERSE_SPACING_SQUARED, inv);
	endtask

	// offer one cell after random idle cycles and wait for its beat
	task automatic send_cell(input logic [VALUE_W-1:0] value, input logic [VALUE_W-1:0] source);
		while ($urandom_range(99) < send_idle_pct) begin
			cell_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cell_ch.valid <= 1'b1;
		cell_ch.cell_value <= value;
		cell_ch.source_value <= source;
		do begin
			@(posedge clk);
		end while (!cell_ch.ready);
		sb.note_cell(value, source);
	endtask

	// q8.24 sample: mostly moderate, some full range, some extremes
	function automatic logic [VALUE_W-1:0] q824_sample();
		logic [31:0] raw;
		int unsigned pick;
		raw = $urandom();
		pick = $urandom_range(99);
		if (pick < 12) begin
			case ($urandom_range(4))
				0: return Q_MAX;
				1: return Q_MIN;
				2: return 32'd0;
				3: return 32'hFFFF_FFFF;
				default: return 32'd1;
			endcase
		end
		if (pick < 40) return raw;
		// within +-2.0 so residual sums mostly stay below saturation
		return {{6{raw[25]}}, raw[25:0]};
	endfunction

	task automatic send_cells(input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			send_cell(q824_sample(), q824_sample());
		end
	endtask

	// stop offering, wait for every pending update, then let the pipeline settle
	task automatic wait_idle();
		cell_ch.valid <= 1'b0;
		while (sb.pending_updates.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one small grid with random geometry and spacing
	task automatic random_grid();
		int unsigned cols, rows;
		logic [31:0] hsq, inv;
		cols = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
		rows = $urandom_range(1, 5);
		case ($urandom_range(5))
			0: hsq = 32'd0;
			1: hsq = 32'hFFFF_FFFF;
			2: hsq = $urandom();
			default: hsq = $urandom_range(1 << 22);
		endcase
		case ($urandom_range(5))
			0: inv = 32'd0;
			1: inv = 32'hFFFF_FFFF;
			2: inv = $urandom();
			default: inv = $urandom_range(1 << 12);
		endcase
		configure(cols, rows, hsq, inv);
		send_cells((cols + 2) * (rows + 2));
		wait_idle();
	endtask

	initial begin : stimulus
		int unsigned phase_start;
		arst_n <= 1'b0;
		write_enable <= 1'b0;
		register_index <= REG_INTERIOR_COLUMNS;
		write_data <= '0;
		cell_ch.valid <= 1'b0;
		cell_ch.cell_value <= '0;
		cell_ch.source_value <= '0;
		long_hold_req = 1'b0;
		// sender mostly busy, receiver mostly stalled
		send_idle_pct = 9;
		recv_idle_pct = 77;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero geometry clamps to one interior cell; spacing keeps its reset value
		write_reg(REG_INTERIOR_COLUMNS, 32'd0);
		write_reg(REG_INTERIOR_ROWS, 32'd0);
		for (int i = 0; i < 9; i++) begin
			send_cell((i == 4) ? 32'd0 : (i % 2 == 0) ? Q_MIN : Q_MAX, Q_MIN);
		end
		wait_idle();

		// full-scale spacing: every laplacian saturates, and so do some updates and residuals
		configure(2, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		for (int i = 0; i < 16; i++) begin
			send_cell((i % 3 == 0) ? Q_MAX : Q_MIN, (i % 2 == 0) ? Q_MAX : Q_MIN);
		end
		wait_idle();

		// wide grid; a long result stall during the emitting row backs up the input
		configure(40, 1, $urandom(), $urandom_range(1 << 12));
		send_cells(80);
		long_hold_req = 1'b1;
		send_cells(42 * 3 - 80);
		wait_idle();

		// tallest height, then cut below the current row mid-grid; the sum carries over
		configure(1, 65535, $urandom(), $urandom_range(1 << 12));
		send_cells(3 * 4);
		wait_idle();
		write_reg(REG_INTERIOR_ROWS, 32'd1);
		send_cells(3);
		wait_idle();

		// width cut mid-row: the waiting column ends the row at once
		configure(6, 3, $urandom(), $urandom_range(1 << 12));
		send_cells(8 * 2 + 5);
		wait_idle();
		write_reg(REG_INTERIOR_COLUMNS, 32'd2);
		send_cells(1 + 4 * 2);
		wait_idle();

		phase_start = sb.cells_noted;
		while (sb.cells_noted - phase_start < CELLS_PER_PHASE) random_grid();

		// sender mostly idle, receiver mostly ready
		send_idle_pct = 77;
		recv_idle_pct = 9;
		phase_start = sb.cells_noted;
		while (sb.cells_noted - phase_start < CELLS_PER_PHASE) random_grid();

		// back to back on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		phase_start = sb.cells_noted;
		while (sb.cells_noted - phase_start < CELLS_PER_PHASE) random_grid();

		$display("run covered %0d cells, %0d jacobi updates checked, %0d grids closed",
			sb.cells_noted, sb.updates_checked, sb.grids_closed);
		$display("geometry from one cell up to wide rows, clamped registers, mid-grid cuts");
		if (sb.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// hard stop if the stream hangs
	initial begin : watchdog
		#(TIMEOUT_NS);
		$error("timeout with %0d updates still pending", sb.pending_updates.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
